// File: sv/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int BYTE_W    = 8;
	localparam int CP_W      = 21;
	localparam int PEND_W    = 2;
	localparam int PART_W    = 15;
	localparam int OUT_TDATA_W = ((CP_W + 7) / 8) * 8;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	typedef struct packed {
		logic [PEND_W-1:0] pending;
		logic [PART_W-1:0] partial;
	} dec_state_t;

	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] code_point;
		logic            malformed;
	} dec_result_t;

endpackage : utf8d_pkg
`default_nettype wire

// File: sv/utf8d_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_step
// One decode step: current state and one byte in, next state and at most
// one code point out.
// ----------------------------------------------------------------------------
module utf8d_step (
	input  wire utf8d_pkg::dec_state_t            state,
	input  wire logic [utf8d_pkg::BYTE_W-1:0]     text_byte,
	input  wire logic                             last_byte,
	output utf8d_pkg::dec_state_t                 state_next,
	output utf8d_pkg::dec_result_t                result
);
	import utf8d_pkg::*;

	logic                cont;
	logic                lead;
	logic [PEND_W-1:0]   lead_n;
	logic [PART_W-1:0]   lead_pv;

	assign cont = (text_byte[7:6] == 2'b10);

	always_comb begin
		lead    = 1'b1;
		lead_n  = 2'd1;
		lead_pv = {{(PART_W-5){1'b0}}, text_byte[4:0]};
		priority if (text_byte[7:5] == 3'b110) begin
			lead_n  = 2'd1;
			lead_pv = {{(PART_W-5){1'b0}}, text_byte[4:0]};
		end else if (text_byte[7:4] == 4'b1110) begin
			lead_n  = 2'd2;
			lead_pv = {{(PART_W-4){1'b0}}, text_byte[3:0]};
		end else if (text_byte[7:3] == 5'b11110) begin
			lead_n  = 2'd3;
			lead_pv = {{(PART_W-3){1'b0}}, text_byte[2:0]};
		end else begin
			lead = 1'b0;
		end
	end

	always_comb begin
		state_next        = state;
		result.emit       = 1'b0;
		result.code_point = {{(CP_W-BYTE_W){1'b0}}, text_byte};
		result.malformed  = 1'b0;
		priority if (state.pending != '0) begin
			priority if (!cont) begin
				state_next        = '0;
				result.emit       = 1'b1;
				result.code_point = REPLACEMENT_CP;
				result.malformed  = 1'b1;
			end else if (state.pending == 2'd1) begin
				state_next        = '0;
				result.emit       = 1'b1;
				result.code_point = {state.partial, text_byte[5:0]};
			end else begin
				state_next.partial = {state.partial[PART_W-7:0], text_byte[5:0]};
				state_next.pending = state.pending - 2'd1;
				if (last_byte) begin
					state_next        = '0;
					result.emit       = 1'b1;
					result.code_point = REPLACEMENT_CP;
					result.malformed  = 1'b1;
				end
			end
		end else if (!text_byte[7]) begin
			result.emit = 1'b1;
		end else if (lead) begin
			if (last_byte) begin
				state_next        = '0;
				result.emit       = 1'b1;
				result.code_point = REPLACEMENT_CP;
				result.malformed  = 1'b1;
			end else begin
				state_next.pending = lead_n;
				state_next.partial = lead_pv;
			end
		end else begin
			// stray continuation or invalid lead
			result.emit       = 1'b1;
			result.code_point = REPLACEMENT_CP;
			result.malformed  = 1'b1;
		end
	end

endmodule : utf8d_step
`default_nettype wire

// File: sv/utf8_to_code_point_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_core
// Lenient streaming UTF-8 decoder: one byte per word in, code points out.
// ----------------------------------------------------------------------------
// An accepted word is registered in the input register, then any result
// it yields in the output register. Throughput: one byte per cycle while
// m_axis_tready does not hold the output back; the decode state updates
// in one step between the input and output registers. Reset: arst_n clears
// the decode state and both valid flags; no sequence is open after reset.
module utf8_to_code_point_decoder_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [utf8d_pkg::BYTE_W-1:0]          s_axis_tdata,  // text_byte
	input  wire logic                                  s_axis_tlast,  // last_byte
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output logic [utf8d_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,  // code_point, pad
	output logic [0:0]                                 m_axis_tuser   // malformed
);
	import utf8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              adv;

	dec_state_t        state_q;
	dec_state_t        state_next;
	dec_result_t       res;

	logic              out_valid_s2;
	logic [CP_W-1:0]   cp_s2;
	logic              bad_s2;

	assign adv           = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	utf8d_step u_step (
		.state      (state_q),
		.text_byte  (byte_s1),
		.last_byte  (last_s1),
		.state_next (state_next),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				state_q      <= state_next;
				out_valid_s2 <= res.emit;
			end else if (m_axis_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			cp_s2  <= res.code_point;
			bad_s2 <= res.malformed;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W-CP_W){1'b0}}, cp_s2};
	assign m_axis_tuser  = bad_s2;

	a_bad_is_repl: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[CP_W-1:0] == REPLACEMENT_CP))
		else $error("malformed word without replacement code point");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (state_q.pending == '0))
		else $error("sequence left open after last byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_s2 && !m_axis_tready))
		else $error("input stalled without downstream backpressure");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("pending result dropped");

endmodule : utf8_to_code_point_decoder_core
`default_nettype wire
